// ----- sv/srwm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srwm_pkg: shared types for the stack region watermark monitor
// Command and response words, per-region entry layout and the command
// broadcast to the row of region cells.
// ----------------------------------------------------------------------------
package srwm_pkg;

	localparam int REGIONS_DEF = 8;  // default table depth
	localparam int IDX_W       = 4;  // width of region_index and found_index
	localparam int SP_STEP     = 2;  // stack pointer step of one push or pop

	typedef enum logic [2:0] {
		MODE_SP_CHANGE,
		MODE_ADD,
		MODE_EDIT,
		MODE_REMOVE,
		MODE_RESET_ONE,
		MODE_RESET_ALL,
		MODE_READ,
		MODE_CHECK_OVERLAP
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [15:0]       old_sp;
		logic [15:0]       new_sp;
		logic [IDX_W-1:0]  region_index;
		logic [15:0]       region_base;
		logic [15:0]       region_limit;
	} in_t;

	typedef struct packed {
		logic              ok;
		logic [IDX_W-1:0]  found_index;
		logic [15:0]       watermark;
		logic [31:0]       push_cnt;
		logic [31:0]       pop_cnt;
		logic [15:0]       entry_base;
		logic [15:0]       entry_limit;
		logic [IDX_W-1:0]  region_count;
	} out_t;

	typedef struct packed {
		logic [15:0] base;
		logic [15:0] limit;
		logic [15:0] watermark;
		logic [31:0] push_cnt;
		logic [31:0] pop_cnt;
	} entry_t;

	// Command broadcast to every cell, with the table-wide decisions already made.
	typedef struct packed {
		logic              go;
		mode_t             mode;
		logic [15:0]       old_sp;
		logic [15:0]       new_sp;
		logic [IDX_W-1:0]  idx;
		logic [15:0]       top;
		logic [15:0]       lim;
		logic              add_ok;
		logic              edit_ok;
		logic              idx_ok;
	} cell_cmd_t;

endpackage
`default_nettype wire

// ----- sv/srwm_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// srwm_cell: one region slot of the monitor
// Holds one table entry, joins the first-hit chain and takes its upper
// neighbor's entry when the table compacts.
// ----------------------------------------------------------------------------
module srwm_cell #(
	parameter int CELL  = 0,
	parameter int CNT_W = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srwm_pkg::cell_cmd_t   cmd,
	input  logic [CNT_W-1:0]      vcnt,
	input  srwm_pkg::entry_t      nb,
	input  logic                  found_in,
	output logic                  found_out,
	output logic                  sel,
	output srwm_pkg::entry_t      ent_q,
	output srwm_pkg::entry_t      ent_d
);
	import srwm_pkg::*;

	logic live, at_idx, at_top, sp_hit, ovl_hit, hit, push_c, pop_c;

	assign live    = CNT_W'(CELL) < vcnt;
	assign at_idx  = IDX_W'(CELL) == cmd.idx;
	assign at_top  = CNT_W'(CELL) == vcnt;

	assign sp_hit  = live && (cmd.new_sp >= ent_q.limit) && (cmd.new_sp <= ent_q.base);
	assign ovl_hit = live && !at_idx && (cmd.lim <= ent_q.base) && (cmd.top >= ent_q.limit);
	assign hit     = (cmd.mode == MODE_SP_CHANGE) ? sp_hit : ovl_hit;

	// first hit wins: pass the found flag on to the next cell
	assign sel       = hit && !found_in;
	assign found_out = found_in || hit;

	assign push_c = ({1'b0, cmd.new_sp} + 17'(SP_STEP)) == {1'b0, cmd.old_sp};
	assign pop_c  = ({1'b0, cmd.old_sp} + 17'(SP_STEP)) == {1'b0, cmd.new_sp};

	always_comb begin
		ent_d = ent_q;
		unique case (cmd.mode)
			MODE_SP_CHANGE: begin
				if (sel) begin
					if (cmd.new_sp < ent_q.watermark) ent_d.watermark = cmd.new_sp;
					if (push_c) ent_d.push_cnt = ent_q.push_cnt + 32'd1;
					else if (pop_c) ent_d.pop_cnt = ent_q.pop_cnt + 32'd1;
				end
			end
			MODE_ADD: begin
				if (cmd.add_ok && at_top) begin
					ent_d = '{base: cmd.top, limit: cmd.lim, watermark: cmd.top,
						push_cnt: '0, pop_cnt: '0};
				end
			end
			MODE_EDIT: begin
				if (cmd.edit_ok && at_idx) begin
					ent_d = '{base: cmd.top, limit: cmd.lim, watermark: cmd.top,
						push_cnt: '0, pop_cnt: '0};
				end
			end
			MODE_REMOVE: begin
				// shift down from the removed slot; the slot past the end holds zero
				if (cmd.idx_ok && live && (IDX_W'(CELL) >= cmd.idx)) ent_d = nb;
			end
			MODE_RESET_ONE: begin
				if (cmd.idx_ok && at_idx) begin
					ent_d.watermark = ent_q.base;
					ent_d.push_cnt  = '0;
					ent_d.pop_cnt   = '0;
				end
			end
			MODE_RESET_ALL: begin
				if (live) begin
					ent_d.watermark = ent_q.base;
					ent_d.push_cnt  = '0;
					ent_d.pop_cnt   = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (cmd.go) begin
			ent_q <= ent_d;
		end
	end

endmodule
`default_nettype wire

// ----- sv/stack_region_watermark_monitor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stack_region_watermark_monitor: stack high-water mark table
// Compacted table of stack regions with low watermark and push/pop counters,
// built as a row of region cells with a first-hit chain through them.
// ----------------------------------------------------------------------------
//
//   channel   signals                          direction   word
//   cmd       cmd_valid, cmd_stall, cmd_word   in          srwm_pkg::in_t
//   rsp       rsp_valid, rsp_stall, rsp_word   out         srwm_pkg::out_t
//
// Every command word is handled in the cycle it is accepted; one per cycle while cmd_stall is low.
// The response is loaded into the response register when the command is accepted.
// The cell row works within that cycle: all cells evaluate, the first-hit chain
// ripples once through REGIONS cells, and cells and response load together.
// cmd_stall rises only while a response is held by rsp_stall.
// Reset clears every entry, the region count and the response valid flag.
//
module stack_region_watermark_monitor #(
	parameter int REGIONS = srwm_pkg::REGIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  srwm_pkg::in_t     cmd_word,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output srwm_pkg::out_t    rsp_word
);
	import srwm_pkg::*;

	localparam int CNT_W = $clog2(REGIONS + 1);
	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	logic [CNT_W-1:0]   vcnt_q, vcnt_d;
	logic               go;
	cell_cmd_t          cmd;
	logic               add_ok, idx_ok, edit_ok;
	logic [REGIONS:0]   chain;
	logic [REGIONS-1:0] sel, rep;
	entry_t             ent_q [REGIONS];
	entry_t             ent_d [REGIONS];
	entry_t             nb_w  [REGIONS];
	logic               ok_c, show_c;
	logic [IDX_W-1:0]   index_c;
	entry_t             pick;

	// Hold the command side only while a response waits on a stalled consumer.
	assign cmd_stall = rsp_valid && rsp_stall;
	assign go        = cmd_valid && !cmd_stall;

	// Table-wide checks, broadcast to the cells with the command.
	assign idx_ok  = CMP_W'(cmd_word.region_index) < CMP_W'(vcnt_q);
	assign add_ok  = (CMP_W'(vcnt_q) < CMP_W'(REGIONS))
		&& (cmd_word.region_base > cmd_word.region_limit);
	// edit also needs no overlap with any other live entry (end of the chain)
	assign edit_ok = idx_ok && (cmd_word.region_base > cmd_word.region_limit)
		&& !chain[REGIONS];

	always_comb begin
		cmd.go      = go;
		cmd.mode    = cmd_word.mode;
		cmd.old_sp  = cmd_word.old_sp;
		cmd.new_sp  = cmd_word.new_sp;
		cmd.idx     = cmd_word.region_index;
		cmd.top     = cmd_word.region_base;
		cmd.lim     = cmd_word.region_limit;
		cmd.add_ok  = add_ok;
		cmd.edit_ok = edit_ok;
		cmd.idx_ok  = idx_ok;
	end

	// Row of region cells; cell 0 starts the first-hit chain, the last cell
	// takes an empty entry from beyond the end when the table compacts.
	assign chain[0] = 1'b0;

	for (genvar g = 0; g < REGIONS; g++) begin : g_cell
		if (g == REGIONS - 1) begin : g_last
			assign nb_w[g] = '0;
		end else begin : g_mid
			assign nb_w[g] = ent_q[g + 1];
		end

		srwm_cell #(
			.CELL  (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.vcnt      (vcnt_q),
			.nb        (nb_w[g]),
			.found_in  (chain[g]),
			.found_out (chain[g + 1]),
			.sel       (sel[g]),
			.ent_q     (ent_q[g]),
			.ent_d     (ent_d[g])
		);
	end

	// Decide which cell reports, and whether the command succeeded.
	always_comb begin
		rep     = '0;
		ok_c    = 1'b0;
		show_c  = 1'b0;
		index_c = IDX_W'(REGIONS);
		pick    = '0;
		unique case (cmd_word.mode) inside
			MODE_SP_CHANGE, MODE_CHECK_OVERLAP: begin
				rep    = sel;
				ok_c   = chain[REGIONS];
				show_c = chain[REGIONS];
			end
			MODE_ADD: begin
				for (int i = 0; i < REGIONS; i++) rep[i] = CNT_W'(i) == vcnt_q;
				ok_c   = add_ok;
				show_c = add_ok;
			end
			MODE_EDIT: begin
				for (int i = 0; i < REGIONS; i++)
					rep[i] = IDX_W'(i) == cmd_word.region_index;
				ok_c   = edit_ok;
				show_c = edit_ok;
			end
			MODE_RESET_ONE, MODE_READ: begin
				for (int i = 0; i < REGIONS; i++)
					rep[i] = IDX_W'(i) == cmd_word.region_index;
				ok_c   = idx_ok;
				show_c = idx_ok;
			end
			MODE_REMOVE: begin
				ok_c = idx_ok;
				if (idx_ok) index_c = cmd_word.region_index;
			end
			MODE_RESET_ALL: begin
				ok_c = 1'b1;
			end
			default: ;
		endcase

		// report the chosen entry as it stands after this command
		if (show_c) begin
			index_c = '0;
			for (int i = 0; i < REGIONS; i++) begin
				if (rep[i]) begin
					pick    = entry_t'(pick | ent_d[i]);
					index_c = index_c | IDX_W'(i);
				end
			end
		end
	end

	always_comb begin
		vcnt_d = vcnt_q;
		if (cmd_word.mode == MODE_ADD && add_ok) vcnt_d = vcnt_q + CNT_W'(1);
		else if (cmd_word.mode == MODE_REMOVE && idx_ok) vcnt_d = vcnt_q - CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q    <= '0;
			rsp_valid <= 1'b0;
		end else if (go) begin
			vcnt_q    <= vcnt_d;
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	// Load the response word with the command; hold it while stalled.
	always_ff @(posedge clk) begin
		if (go) begin
			rsp_word.ok           <= ok_c;
			rsp_word.found_index  <= index_c;
			rsp_word.watermark    <= pick.watermark;
			rsp_word.push_cnt     <= pick.push_cnt;
			rsp_word.pop_cnt      <= pick.pop_cnt;
			rsp_word.entry_base   <= pick.base;
			rsp_word.entry_limit  <= pick.limit;
			rsp_word.region_count <= IDX_W'(vcnt_d);
		end
	end

endmodule
`default_nettype wire
